@@ hw/rtl/assert_macros.svh @@
// assertion macros for the radix digit converter
// uses clk_i and rst_ni of the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RDC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define RDC_ASSERT_IMPLIES(lbl, ante, cons)
`define RDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/rdc_pkg.sv @@
// shared types and constants of the radix digit converter
// no dependencies
package rdc_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CHUNK_BITS = 8;
  localparam int unsigned CHUNK_W    = 2;   // four chunks of eight bits per division

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHUNK_W-1:0] CHUNK_LAST = 2'd3;

  // controller state codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  // controller to datapath
  typedef struct packed {
    logic start;       // load a new value
    logic step;        // one chunk of long division
    logic last_chunk;  // step finishes a digit
    logic load_out;    // move next stored digit into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic quot_zero;   // quotient after this digit is zero
    logic store_full;  // this digit fills the store
    logic rd_last;     // read pointer at least significant digit
    logic out_free;    // output register can take a digit
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

@@ hw/rtl/rdc_ctrl.sv @@
// controller state machine of the radix digit converter
// depends on rdc_pkg
module rdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rdc_pkg::sts_t sts_i,
  output rdc_pkg::cmd_t cmd_o
);
  import rdc_pkg::*;

  logic [1:0]         state_q, state_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    chunk_d          = chunk_q;
    cmd_o            = '0;
    cmd_o.last_chunk = (chunk_q == CHUNK_LAST);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          chunk_d     = '0;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        chunk_d    = chunk_q + 1'b1;
        if (cmd_o.last_chunk && (sts_i.quot_zero || sts_i.store_full)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free && sts_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chunk_q <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
    end
  end

endmodule

@@ hw/rtl/rdc_datapath.sv @@
// datapath of the radix digit converter: radix register, chunked long
// division, digit store and output register; depends on rdc_pkg
module rdc_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rdc_pkg::RADIX_W-1:0]      cfg_radix_i,
  input  logic [rdc_pkg::VALUE_W-1:0]      value_i,
  input  rdc_pkg::cmd_t                    cmd_i,
  output rdc_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rdc_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                             last_digit_o
);
  import rdc_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [RADIX_W-1:0]    radix_q;
  logic [VALUE_W-1:0]    quot_q, quot_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [CHUNK_BITS-1:0] qbits;
  logic [IDX_W-1:0]      wr_idx_q, rd_ptr_q;
  logic                  out_valid_q;
  logic [CHAR_W-1:0]     out_char_q;
  logic                  out_last_q;
  logic [REM_W-1:0]      store [DEPTH];

  // eight restoring steps; remainder stays below the radix
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r = rem_q;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t = {r, quot_q[VALUE_W-1-i]};
      if (t >= radix_q) begin
        t                       = t - radix_q;
        qbits[CHUNK_BITS-1-i]   = 1'b1;
      end else begin
        qbits[CHUNK_BITS-1-i]   = 1'b0;
      end
      r = t[REM_W-1:0];
    end
    rem_d  = r;
    quot_d = {quot_q[VALUE_W-CHUNK_BITS-1:0], qbits};
  end

  assign sts_o.quot_zero  = (quot_d == '0);
  assign sts_o.store_full = (wr_idx_q == IDX_W'(DEPTH - 1));
  assign sts_o.rd_last    = (rd_ptr_q == '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RESET;
      out_valid_q <= 1'b0;
      wr_idx_q    <= '0;
      rd_ptr_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_radix_i >= RADIX_MIN && cfg_radix_i <= RADIX_MAX) begin
        radix_q <= cfg_radix_i;
      end
      if (cmd_i.start) begin
        wr_idx_q <= '0;
      end else if (cmd_i.step && cmd_i.last_chunk) begin
        wr_idx_q <= wr_idx_q + 1'b1;
        rd_ptr_q <= wr_idx_q;
      end else if (cmd_i.load_out) begin
        rd_ptr_q <= rd_ptr_q - 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quot_q <= value_i;
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      quot_q <= quot_d;
      rem_q  <= cmd_i.last_chunk ? '0 : rem_d;
    end
    if (cmd_i.step && cmd_i.last_chunk) begin
      store[wr_idx_q] <= rem_d;
    end
    if (cmd_i.load_out) begin
      out_char_q <= digit_char(store[rd_ptr_q]);
      out_last_q <= (rd_ptr_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;

endmodule

@@ hw/rtl/radix_digit_converter_unit.sv @@
// top level of the radix digit converter
// instantiates rdc_ctrl and rdc_datapath; uses rdc_pkg and assert_macros.svh
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_radix_i (5b, 2..16)
//  in      | in        | in_valid_i / in_stall_o   | value_i (32b)
//  out     | out       | out_valid_o / out_stall_i | digit_char_o, last_digit_o
//
// each digit is divided out chunk by chunk (8 quotient bits per cycle
// through the shared restoring divider), then digits leave one per cycle
// while the output register is free to take them
// reset puts the radix at 10 and empties the output register; the digit
// store needs no clearing since every digit is written before it is read
// output stalls only hold the emit phase; a new request is taken while the
// last digit of the previous one still waits in the output register
`include "assert_macros.svh"

module radix_digit_converter_unit #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_radix_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rdc_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_digit_o
);
  import rdc_pkg::*;

  // a 32-bit value never needs more than 32 digits
  localparam int unsigned DEPTH = (MAX_DIGITS < VALUE_W) ? MAX_DIGITS : VALUE_W;

  cmd_t cmd;
  sts_t sts;

  // radix register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  rdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_radix_i  (cfg_radix_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  // accepted request always starts division
  `RDC_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)
  // loading the last digit frees the input side
  `RDC_ASSERT_NEXT(a_last_frees_input, cmd.load_out && sts.rd_last, !in_stall_o)
  // division and emitting never overlap
  `RDC_ASSERT_IMPLIES(a_step_no_load, cmd.step, !cmd.load_out && !cmd.start)

endmodule

@@ sim/digit_stream_checker.sv @@
`timescale 1ns / 1ps
// digit stream checker of the radix digit converter: follows the radix writes and
// the accepted values, predicts each value's digit run and compares it on the output
// depends on rdc_pkg for widths and radix limits
module digit_stream_checker #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_radix_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [rdc_pkg::VALUE_W-1:0] value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [rdc_pkg::CHAR_W-1:0]  digit_char_i,
  input  logic                        last_digit_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_digits_o
);
  import rdc_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } digit_t;

  digit_t             expected_digits[$];
  logic [RADIX_W-1:0] radix_q;
  int unsigned        mismatches = 0;

  // repeated division, remainders collected least significant first
  function automatic void queue_digits(input logic [VALUE_W-1:0] value,
                                       input logic [RADIX_W-1:0] base);
    logic [REM_W-1:0]   rems[MAX_DIGITS];
    logic [VALUE_W-1:0] quot;
    int                 n;
    digit_t             rec;
    quot = value;
    n    = 0;
    do begin
      if (n >= MAX_DIGITS || n >= VALUE_W) break;
      rems[n] = REM_W'(quot % base);
      n++;
      quot = quot / base;
    end while (quot != 0);
    for (int k = n - 1; k >= 0; k--) begin
      rec.char_code = (rems[k] < 10) ? CHAR_W'(7'h30 + rems[k]) : CHAR_W'(7'h61 + rems[k] - 10);
      rec.is_last   = (k == 0);
      expected_digits.push_back(rec);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    digit_t want;
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
    end else begin
      // out of range writes leave the radix alone
      if (cfg_valid_i && cfg_ready_i && cfg_radix_i >= RADIX_MIN && cfg_radix_i <= RADIX_MAX)
        radix_q = cfg_radix_i;
      if (in_valid_i && !in_stall_i) queue_digits(value_i, radix_q);
      if (out_valid_i && !out_stall_i) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: digit with no request pending, char %h last %b",
                   $time, digit_char_i, last_digit_i);
          mismatches++;
        end else begin
          want = expected_digits.pop_front();
          if (digit_char_i !== want.char_code) begin
            $display("%0t: digit_char expected %h actual %h",
                     $time, want.char_code, digit_char_i);
            mismatches++;
          end
          if (last_digit_i !== want.is_last) begin
            $display("%0t: last_digit expected %b actual %b",
                     $time, want.is_last, last_digit_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_digits_o <= expected_digits.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// top of the radix digit converter bench: clock, reset, radix writes, value requests
// and output stalls; instantiates radix_digit_converter_unit and digit_stream_checker
module testbench;
  import rdc_pkg::*;

  localparam int unsigned DIGIT_CAPACITY = 32;
  localparam int unsigned RANDOM_ITEMS   = 280;
  // slowest request is radix 2 at 32 digits, stretched by random output
  // stalls and by the long receiver hold
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_radix_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_digit_o;

  int unsigned mismatch_count;
  int unsigned pending_digits;
  int unsigned idle_pct = 36;   // shared by the sender and the receiver
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  radix_digit_converter_unit #(
    .MAX_DIGITS (DIGIT_CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_radix_i  (cfg_radix_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  digit_stream_checker #(
    .MAX_DIGITS (DIGIT_CAPACITY)
  ) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_radix_i      (cfg_radix_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_char_i     (digit_char_o),
    .last_digit_i     (last_digit_o),
    .mismatch_count_o (mismatch_count),
    .pending_digits_o (pending_digits)
  );

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  // so that the output register and then the input back up
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one value request; valid stays up across back-to-back requests and the
  // payload holds while the block stalls
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // block is idle once every digit expected so far has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_digits != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // radix write, only while idle; illegal values are offered too
  task automatic write_radix(input logic [RADIX_W-1:0] radix);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= radix;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mix of zero, full-range, shortened and near-maximum values
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return $urandom >> $urandom_range(31, 0);
      2:       return 32'hFFFF_FFFF - $urandom_range(3, 0);
      3:       return $urandom_range(255, 0);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned phase;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_radix_i = '0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset radix 10, extremes of the value
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    // radix 2: longest runs
    write_radix(5'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    // radix 16: all letter digits
    write_radix(5'd16);
    send_value(32'hFFFF_FFFF);
    send_value(32'hDEAD_BEEF);
    send_value(32'h0123_4567);
    send_value(32'h89AB_CDEF);
    send_value(32'd16);
    // out of range writes keep radix 16
    write_radix(5'd17);
    send_value(32'd255);
    write_radix(5'd1);
    write_radix(5'd0);
    write_radix(5'd31);
    send_value(32'hABCD_0000);
    write_radix(5'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'd8);

    // random phases, each under its own radix
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3, 0) == 0) write_radix(5'($urandom_range(31, 0)));
      write_radix((phase % 5 == 0) ? 5'(2 + 14 * ((phase / 5) % 2)) :
                                     5'($urandom_range(16, 2)));
      // a stretch with no idling on either side
      idle_pct = (phase == 3) ? 0 : 36;
      // long receiver hold while the sender keeps offering
      if (phase == 6) hold_request = 1'b1;
      burst = $urandom_range(30, 15);
      for (int i = 0; i < burst; i++) send_value(pick_value());
      sent  += burst;
      phase++;
    end

    wait_drained();
    if (mismatch_count == 0 && pending_digits == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
